// ----- rtl/core/y2rgb_pkg.sv -----
`default_nettype none
package y2rgb_pkg;

  // field and register widths
  localparam int PIX_W = 8;
  localparam int DIM_W = 13;

  // largest frame the counters cover
  localparam int MAX_WIDTH  = 4096;
  localparam int MAX_HEIGHT = 4096;
  localparam int CNT_W = $clog2((MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT);
  localparam int CMP_W = ((DIM_W > CNT_W) ? DIM_W : CNT_W) + 1;

  // register reset values
  localparam logic [DIM_W-1:0] WIDTH_RESET  = DIM_W'(1920);
  localparam logic [DIM_W-1:0] HEIGHT_RESET = DIM_W'(1080);

  // configuration register map
  localparam int CFG_IDX_W = 1;
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } cfg_reg_t;

  // queue between front and back
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  // bt.601 full-range coefficients, 16 fractional bits
  localparam int PROD_W = 26;
  localparam int OFF_W  = 9;
  localparam logic signed [17:0] C_RV = 18'sd91881;
  localparam logic signed [17:0] C_GU = 18'sd22554;
  localparam logic signed [17:0] C_GV = 18'sd46802;
  localparam logic signed [17:0] C_BU = 18'sd116130;

  // one classified macropixel
  typedef struct packed {
    logic [PIX_W-1:0] luma_first;
    logic [PIX_W-1:0] chroma_blue;
    logic [PIX_W-1:0] luma_second;
    logic [PIX_W-1:0] chroma_red;
    logic             two;
    logic             lend;
    logic             fend;
  } y2rgb_cmd_t;

  // luma plus signed chroma offset, clamped to 0..255
  function automatic logic [PIX_W-1:0] clamp_add(input logic [PIX_W-1:0] y,
                                                 input logic signed [OFF_W-1:0] off);
    logic signed [OFF_W:0] sum;
    sum = $signed({2'b00, y}) + $signed({off[OFF_W-1], off});
    if (sum[OFF_W]) begin
      clamp_add = '0;
    end else if (sum[PIX_W]) begin
      clamp_add = '1;
    end else begin
      clamp_add = sum[PIX_W-1:0];
    end
  endfunction

endpackage
`default_nettype wire

// ----- rtl/core/y2rgb_if.sv -----
`default_nettype none
interface y2rgb_in_if import y2rgb_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] luma_first;
  logic [PIX_W-1:0] chroma_blue;
  logic [PIX_W-1:0] luma_second;
  logic [PIX_W-1:0] chroma_red;

  modport source(output valid, luma_first, chroma_blue, luma_second, chroma_red,
                 input ready);
  modport sink(input valid, luma_first, chroma_blue, luma_second, chroma_red,
               output ready);
endinterface

interface y2rgb_out_if import y2rgb_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] red;
  logic [PIX_W-1:0] green;
  logic [PIX_W-1:0] blue;
  logic             last_of_item;
  logic             line_end;
  logic             frame_end;

  modport source(output valid, red, green, blue, last_of_item, line_end, frame_end,
                 input ready);
  modport sink(input valid, red, green, blue, last_of_item, line_end, frame_end,
               output ready);
endinterface
`default_nettype wire

// ----- rtl/core/y2rgb_front.sv -----
`default_nettype none
module y2rgb_front import y2rgb_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  y2rgb_in_if.sink              pix_in,
  input  wire logic [DIM_W-1:0] frame_width,
  input  wire logic [DIM_W-1:0] frame_height,
  output      logic             push_valid,
  input  wire logic             push_ready,
  output      y2rgb_cmd_t       push_cmd
);

  logic [CNT_W-1:0] column_count;
  logic [CNT_W-1:0] row_count;
  logic [CMP_W-1:0] w_eff, h_eff, x_ext, x_plus2;
  logic             two, lend, fend, accept;

  // effective size: zero acts as one, oversize saturates
  always_comb begin
    priority if (frame_width == '0) begin
      w_eff = CMP_W'(1);
    end else if (CMP_W'(frame_width) > CMP_W'(MAX_WIDTH)) begin
      w_eff = CMP_W'(MAX_WIDTH);
    end else begin
      w_eff = CMP_W'(frame_width);
    end
    priority if (frame_height == '0) begin
      h_eff = CMP_W'(1);
    end else if (CMP_W'(frame_height) > CMP_W'(MAX_HEIGHT)) begin
      h_eff = CMP_W'(MAX_HEIGHT);
    end else begin
      h_eff = CMP_W'(frame_height);
    end
  end

  assign x_ext   = CMP_W'(column_count);
  assign x_plus2 = x_ext + CMP_W'(2);
  assign two     = (x_ext + CMP_W'(1)) < w_eff;
  assign lend    = x_plus2 >= w_eff;
  assign fend    = lend && ((CMP_W'(row_count) + CMP_W'(1)) >= h_eff);

  assign accept       = pix_in.valid && push_ready;
  assign pix_in.ready = push_ready;
  assign push_valid   = pix_in.valid;

  always_comb begin
    push_cmd.luma_first  = pix_in.luma_first;
    push_cmd.chroma_blue = pix_in.chroma_blue;
    push_cmd.luma_second = pix_in.luma_second;
    push_cmd.chroma_red  = pix_in.chroma_red;
    push_cmd.two         = two;
    push_cmd.lend        = lend;
    push_cmd.fend        = fend;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (accept) begin
      if (lend) begin
        column_count <= '0;
        row_count    <= fend ? '0 : row_count + CNT_W'(1);
      end else begin
        column_count <= x_plus2[CNT_W-1:0];
      end
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/y2rgb_queue.sv -----
`default_nettype none
module y2rgb_queue import y2rgb_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       push_valid,
  output      logic       push_ready,
  input  wire y2rgb_cmd_t push_cmd,
  output      logic       pop_valid,
  input  wire logic       pop_ready,
  output      y2rgb_cmd_t pop_cmd
);

  y2rgb_cmd_t         mem [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr, rd_ptr;
  logic [Q_CNT_W-1:0] count;
  logic               do_push, do_pop;

  assign push_ready = count != Q_CNT_W'(Q_DEPTH);
  assign pop_valid  = count != '0;
  assign pop_cmd    = mem[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  function automatic logic [Q_PTR_W-1:0] ptr_inc(input logic [Q_PTR_W-1:0] p);
    ptr_inc = (p == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : p + Q_PTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (do_pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (do_push && !do_pop) begin
        count <= count + Q_CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - Q_CNT_W'(1);
      end
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/y2rgb_back.sv -----
`default_nettype none
module y2rgb_back import y2rgb_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       pop_valid,
  output      logic       pop_ready,
  input  wire y2rgb_cmd_t pop_cmd,
  y2rgb_out_if.source     pix_out
);

  // chroma stage
  logic                    a_valid, a_phase;
  logic [PIX_W-1:0]        a_y0, a_y1;
  logic signed [OFF_W-1:0] a_roff, a_goff, a_boff;
  logic                    a_two, a_lend, a_fend;

  // output register
  logic                    o_valid;
  logic [PIX_W-1:0]        o_red, o_green, o_blue;
  logic                    o_last, o_lend, o_fend;

  logic signed [PIX_W-1:0]  d, e;
  logic signed [PROD_W-1:0] r_prod, g_sum, b_prod;
  logic                     a_done, a_take, o_load;
  logic [PIX_W-1:0]         y_sel;

  // remove the 128 offset by flipping the top bit
  assign d = {~pop_cmd.chroma_blue[PIX_W-1], pop_cmd.chroma_blue[PIX_W-2:0]};
  assign e = {~pop_cmd.chroma_red[PIX_W-1], pop_cmd.chroma_red[PIX_W-2:0]};

  assign r_prod = PROD_W'(C_RV) * PROD_W'(e);
  assign g_sum  = PROD_W'(C_GU) * PROD_W'(d) + PROD_W'(C_GV) * PROD_W'(e);
  assign b_prod = PROD_W'(C_BU) * PROD_W'(d);

  assign a_done    = a_phase || !a_two;
  assign o_load    = a_valid && (!o_valid || pix_out.ready);
  assign a_take    = !a_valid || (o_load && a_done);
  assign pop_ready = a_take;
  assign y_sel     = a_phase ? a_y1 : a_y0;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      a_phase <= 1'b0;
      o_valid <= 1'b0;
    end else begin
      if (a_take) begin
        a_valid <= pop_valid;
        a_phase <= 1'b0;
      end else if (o_load) begin
        a_phase <= 1'b1;
      end
      if (o_load) begin
        o_valid <= 1'b1;
      end else if (pix_out.ready) begin
        o_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_take && pop_valid) begin
      a_y0   <= pop_cmd.luma_first;
      a_y1   <= pop_cmd.luma_second;
      // floor shift by 16: the quotient fits the low bits above the fraction
      a_roff <= r_prod[16 +: OFF_W];
      a_goff <= -g_sum[16 +: OFF_W];
      a_boff <= b_prod[16 +: OFF_W];
      a_two  <= pop_cmd.two;
      a_lend <= pop_cmd.lend;
      a_fend <= pop_cmd.fend;
    end
    if (o_load) begin
      o_red   <= clamp_add(y_sel, a_roff);
      o_green <= clamp_add(y_sel, a_goff);
      o_blue  <= clamp_add(y_sel, a_boff);
      o_last  <= a_done;
      o_lend  <= a_done && a_lend;
      o_fend  <= a_done && a_fend;
    end
  end

  assign pix_out.valid        = o_valid;
  assign pix_out.red          = o_red;
  assign pix_out.green        = o_green;
  assign pix_out.blue         = o_blue;
  assign pix_out.last_of_item = o_last;
  assign pix_out.line_end     = o_lend;
  assign pix_out.frame_end    = o_fend;

endmodule
`default_nettype wire

// ----- rtl/core/yuyv_to_rgb888_converter.sv -----
// path: a taken word is written to the queue, then to the chroma stage; its first pixel and
// then its second go to the output register; one pixel per cycle while the output is ready
// rate is set by the single-pixel output register; a 2-entry queue decouples input from output
// reset (rst, synchronous): column and row counters zero, queue and pipeline empty,
// frame_width back to 1920 and frame_height back to 1080
`default_nettype none
module yuyv_to_rgb888_converter import y2rgb_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [DIM_W-1:0]     cfg_data,
  y2rgb_in_if.sink                  pix_in,
  y2rgb_out_if.source               pix_out
);

  // configuration registers: the user writes them only while the block is idle (not enforced)
  logic [DIM_W-1:0] frame_width;
  logic [DIM_W-1:0] frame_height;

  // front to queue
  logic       push_valid, push_ready;
  y2rgb_cmd_t push_cmd;

  // queue to back
  logic       pop_valid, pop_ready;
  y2rgb_cmd_t pop_cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= WIDTH_RESET;
      frame_height <= HEIGHT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH:  frame_width  <= cfg_data;
        REG_FRAME_HEIGHT: frame_height <= cfg_data;
      endcase
    end
  end

  // front: takes a word, works out pixel count and line/frame end flags,
  // advances the column and row counters
  y2rgb_front u_front (
    .clk          (clk),
    .rst          (rst),
    .pix_in       (pix_in),
    .frame_width  (frame_width),
    .frame_height (frame_height),
    .push_valid   (push_valid),
    .push_ready   (push_ready),
    .push_cmd     (push_cmd)
  );

  // short queue so front and back stall independently
  y2rgb_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_cmd    (pop_cmd)
  );

  // back: chroma products registered once per word, then one or two
  // clamped pixels go out through the output register
  y2rgb_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_cmd   (pop_cmd),
    .pix_out   (pix_out)
  );

endmodule
`default_nettype wire

// ----- tb/rgb_pixel_checker.sv -----
`timescale 1ns / 1ps
module rgb_pixel_checker import y2rgb_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  cfg_reg_t         cfg_index,
  input  logic [DIM_W-1:0] cfg_data,
  y2rgb_in_if              word_in,
  y2rgb_out_if             pixel_out,
  output int               fail_count,
  output int               pending,
  output int               pixels_checked,
  output int               lines_seen,
  output int               frames_seen
);

  // bt.601 full-range weights, 16 fractional bits
  localparam int K_RV = 91881;
  localparam int K_GU = 22554;
  localparam int K_GV = 46802;
  localparam int K_BU = 116130;

  typedef struct packed {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
    logic             last_of_item;
    logic             line_end;
    logic             frame_end;
  } rgb_pixel_t;

  rgb_pixel_t       rgb_due[$];
  logic [DIM_W-1:0] frame_width;
  logic [DIM_W-1:0] frame_height;
  int               col;
  int               row;

  function automatic logic [PIX_W-1:0] sat8(input int v);
    if (v < 0) return '0;
    if (v > 255) return '1;
    return v[PIX_W-1:0];
  endfunction

  function automatic rgb_pixel_t shade(input int y, input int du, input int dv,
                                       input logic last, input logic lend,
                                       input logic fend);
    rgb_pixel_t p;
    // signed int shifts floor, as the fixed-point datapath does
    p.red          = sat8(y + ((K_RV * dv) >>> 16));
    p.green        = sat8(y - ((K_GU * du + K_GV * dv) >>> 16));
    p.blue         = sat8(y + ((K_BU * du) >>> 16));
    p.last_of_item = last;
    p.line_end     = lend;
    p.frame_end    = fend;
    return p;
  endfunction

  task automatic convert_word(input logic [PIX_W-1:0] y0, input logic [PIX_W-1:0] u,
                              input logic [PIX_W-1:0] y1, input logic [PIX_W-1:0] v);
    int   w;
    int   h;
    int   du;
    int   dv;
    logic two;
    logic lend;
    logic fend;
    w = int'(frame_width);
    h = int'(frame_height);
    if (w == 0) w = 1;
    else if (w > MAX_WIDTH) w = MAX_WIDTH;
    if (h == 0) h = 1;
    else if (h > MAX_HEIGHT) h = MAX_HEIGHT;
    du = int'(u) - 128;
    dv = int'(v) - 128;
    two  = (col + 1) < w;
    lend = (col + 2) >= w;
    fend = lend && ((row + 1) >= h);
    if (two) begin
      rgb_due.push_back(shade(int'(y0), du, dv, 1'b0, 1'b0, 1'b0));
      rgb_due.push_back(shade(int'(y1), du, dv, 1'b1, lend, fend));
    end else begin
      rgb_due.push_back(shade(int'(y0), du, dv, 1'b1, lend, fend));
    end
    if (lend) begin
      col = 0;
      row = fend ? 0 : row + 1;
    end else begin
      col = col + 2;
    end
  endtask

  always @(posedge clk) begin : watch
    rgb_pixel_t got;
    rgb_pixel_t want;
    if (rst) begin
      frame_width    = WIDTH_RESET;
      frame_height   = HEIGHT_RESET;
      col            = 0;
      row            = 0;
      rgb_due.delete();
      fail_count     = 0;
      pixels_checked = 0;
      lines_seen     = 0;
      frames_seen    = 0;
    end else begin
      if (word_in.valid && word_in.ready) begin
        convert_word(word_in.luma_first, word_in.chroma_blue,
                     word_in.luma_second, word_in.chroma_red);
      end
      if (pixel_out.valid && pixel_out.ready) begin
        got = '{pixel_out.red, pixel_out.green, pixel_out.blue,
                pixel_out.last_of_item, pixel_out.line_end, pixel_out.frame_end};
        if (rgb_due.size() == 0) begin
          fail_count++;
          $display("%0t unexpected pixel: expected none, got r=%0d g=%0d b=%0d last=%b line=%b frame=%b",
                   $time, got.red, got.green, got.blue,
                   got.last_of_item, got.line_end, got.frame_end);
        end else begin
          want = rgb_due.pop_front();
          pixels_checked++;
          if (got.line_end === 1'b1) lines_seen++;
          if (got.frame_end === 1'b1) frames_seen++;
          if (got.red !== want.red || got.green !== want.green || got.blue !== want.blue ||
              got.last_of_item !== want.last_of_item || got.line_end !== want.line_end ||
              got.frame_end !== want.frame_end) begin
            fail_count++;
            $display("%0t pixel mismatch: expected r=%0d g=%0d b=%0d last=%b line=%b frame=%b",
                     $time, want.red, want.green, want.blue,
                     want.last_of_item, want.line_end, want.frame_end);
            $display("%0t                 got      r=%0d g=%0d b=%0d last=%b line=%b frame=%b",
                     $time, got.red, got.green, got.blue,
                     got.last_of_item, got.line_end, got.frame_end);
          end
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_FRAME_WIDTH:  frame_width = cfg_data;
          REG_FRAME_HEIGHT: frame_height = cfg_data;
          default: ;
        endcase
      end
    end
    pending = rgb_due.size();
  end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
module tb_top;
  import y2rgb_pkg::*;

  // generous ceiling: roughly 600 words, worst case stalls included
  localparam int CYCLE_LIMIT = 300000;

  logic             clk = 1'b0;
  logic             rst;
  logic             cfg_we;
  cfg_reg_t         cfg_index;
  logic [DIM_W-1:0] cfg_data;

  // idle mix, in percent per cycle
  int   send_idle = 0;
  int   stall_pct = 0;

  // long output hold-off, requested by the stimulus, counted by the receiver
  int   hold_len  = 0;
  logic hold_go   = 1'b0;
  logic hold_seen = 1'b0;
  int   hold_left = 0;

  int   words_sent = 0;
  int   cycles     = 0;

  int   fail_count;
  int   pending;
  int   pixels_checked;
  int   lines_seen;
  int   frames_seen;

  y2rgb_in_if  pix_in();
  y2rgb_out_if pix_out();

  yuyv_to_rgb888_converter dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .pix_in   (pix_in),
    .pix_out  (pix_out)
  );

  // watches both channels and the register port, predicts and compares
  rgb_pixel_checker chk (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .word_in       (pix_in),
    .pixel_out     (pix_out),
    .fail_count    (fail_count),
    .pending       (pending),
    .pixels_checked(pixels_checked),
    .lines_seen    (lines_seen),
    .frames_seen   (frames_seen)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t run aborted after %0d cycles, %0d pixels still due", $time, cycles, pending);
      $display("yuyv_to_rgb888_converter regression: fail");
      $finish;
    end
  end

  // pixel receiver: random stalls, plus a long hold-off on request
  always @(negedge clk) begin
    if (hold_go != hold_seen) begin
      hold_seen = hold_go;
      hold_left = hold_len;
    end
    if (hold_left > 0) begin
      hold_left--;
      pix_out.ready = 1'b0;
    end else begin
      pix_out.ready = (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
    end
  end

  // bytes lean toward the ends of the range so the clamps get hit often
  function automatic logic [PIX_W-1:0] rand_byte();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      2: return PIX_W'(128);
      default: return PIX_W'($urandom_range(255));
    endcase
  endfunction

  // offer one word, entered and left at a falling edge; valid stays high on return
  task automatic send_word(input logic [PIX_W-1:0] y0, input logic [PIX_W-1:0] u,
                           input logic [PIX_W-1:0] y1, input logic [PIX_W-1:0] v);
    while (send_idle > 0 && $urandom_range(99) < send_idle) begin
      pix_in.valid = 1'b0;
      @(negedge clk);
    end
    pix_in.valid       = 1'b1;
    pix_in.luma_first  = y0;
    pix_in.chroma_blue = u;
    pix_in.luma_second = y1;
    pix_in.chroma_red  = v;
    do @(posedge clk); while (!pix_in.ready);
    words_sent++;
    @(negedge clk);
  endtask

  task automatic send_random(input int count);
    for (int i = 0; i < count; i++) begin
      send_word(rand_byte(), rand_byte(), rand_byte(), rand_byte());
    end
  endtask

  // drop valid and wait until every predicted pixel has come out
  task automatic settle();
    pix_in.valid = 1'b0;
    while (pending != 0) @(negedge clk);
    // then wait on, so a stray pixel that was never predicted is caught here
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [DIM_W-1:0] value);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  // sizes are only changed with the block idle
  task automatic set_frame(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h);
    settle();
    write_reg(REG_FRAME_WIDTH, w);
    write_reg(REG_FRAME_HEIGHT, h);
  endtask

  initial begin : stimulus
    int w;
    int h;
    int n;
    int cnt;
    rst                 = 1'b1;
    cfg_we              = 1'b0;
    cfg_index           = REG_FRAME_WIDTH;
    cfg_data            = '0;
    pix_in.valid        = 1'b0;
    pix_in.luma_first   = '0;
    pix_in.chroma_blue  = '0;
    pix_in.luma_second  = '0;
    pix_in.chroma_red   = '0;
    pix_out.ready       = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: 4x2 frame, extremes of luma and both chroma offsets
    set_frame(4, 2);
    send_word(8'd0,   8'd0,   8'd0,   8'd0);
    send_word(8'd255, 8'd255, 8'd255, 8'd255);
    send_word(8'd255, 8'd0,   8'd255, 8'd0);
    send_word(8'd0,   8'd255, 8'd0,   8'd255);
    send_word(8'd128, 8'd128, 8'd128, 8'd128);
    send_word(8'd255, 8'd0,   8'd0,   8'd255);
    send_word(8'd0,   8'd255, 8'd255, 8'd0);
    send_word(8'd16,  8'd127, 8'd235, 8'd129);

    // odd width: last word of a line yields only its first pixel
    set_frame(3, 2);
    send_word(8'd1,   8'd200, 8'd2,   8'd50);
    send_word(8'd254, 8'd60,  8'd253, 8'd190);
    send_word(8'd100, 8'd1,   8'd101, 8'd254);
    send_word(8'd90,  8'd254, 8'd91,  8'd1);

    // zero width and height act as one: every word ends line and frame
    set_frame(0, 0);
    send_word(8'd77,  8'd33,  8'd99,  8'd222);
    send_word(8'd0,   8'd128, 8'd255, 8'd128);
    send_word(8'd255, 8'd64,  8'd0,   8'd192);

    // shrink both sizes while mid-line on the second row
    set_frame(6, 3);
    send_word(8'd10,  8'd20,  8'd30,  8'd40);
    send_word(8'd50,  8'd60,  8'd70,  8'd80);
    send_word(8'd90,  8'd100, 8'd110, 8'd120);
    send_word(8'd130, 8'd140, 8'd150, 8'd160);
    send_word(8'd170, 8'd180, 8'd190, 8'd200);
    set_frame(2, 1);
    // column past width and row past height: one pixel ends line and frame
    send_word(8'd210, 8'd220, 8'd230, 8'd240);
    send_word(8'd250, 8'd5,   8'd15,  8'd25);

    // random part in four idle mixes
    for (int phase = 0; phase < 4; phase++) begin
      settle();
      case (phase)
        0: begin send_idle = 0;  stall_pct = 0;  end
        1: begin send_idle = 70; stall_pct = 0;  end
        2: begin send_idle = 0;  stall_pct = 70; end
        default: begin send_idle = 25; stall_pct = 25; end
      endcase

      if (phase == 0) begin
        // hold the output off while words keep coming so the queue backs up
        set_frame(16, 4);
        hold_len = 80;
        hold_go  = ~hold_go;
        send_random(12);
        // sender pauses until every pixel is out, then resumes
        settle();
        send_random(20);
        // an oversize width (all register bits set) acts as the largest width; the height is the largest one
        set_frame(8191, 4096);
        send_random(16);
      end

      n = 0;
      while (n < 110) begin
        case ($urandom_range(9))
          0:       w = 0;
          1:       w = $urandom_range(13, 64);
          default: w = $urandom_range(1, 12);
        endcase
        h = ($urandom_range(7) == 0) ? 0 : $urandom_range(1, 4);
        set_frame(DIM_W'(w), DIM_W'(h));
        // mostly whole frames; sometimes stop mid-line so the next size hits a partial line
        cnt = (((w == 0) ? 1 : w) + 1) / 2 * ((h == 0) ? 1 : h);
        if ($urandom_range(3) == 0) cnt += $urandom_range(1, 3);
        send_random(cnt);
        n += cnt;
      end
    end

    // drain with a bound, then wait on to catch stray pixels
    pix_in.valid = 1'b0;
    n = 0;
    while (pending != 0 && n < 2000) begin
      @(negedge clk);
      n++;
    end
    repeat (8) @(negedge clk);
    if (pending != 0) $display("%0t %0d predicted pixels never came out", $time, pending);

    $display("sent %0d words; checked %0d pixels, %0d line ends, %0d frame ends",
             words_sent, pixels_checked, lines_seen, frames_seen);
    $display("sizes zero to oversize, odd widths, mid-line shrinks, four idle mixes, long hold-off");
    if (fail_count == 0 && pending == 0) begin
      $display("yuyv_to_rgb888_converter regression: pass");
    end else begin
      $display("yuyv_to_rgb888_converter regression: fail");
    end
    $finish;
  end

endmodule
